>>> hdl/lss_pkg.sv
// lss_pkg: shared widths, defaults and operation/status codes for the LIFO stack with search.
// No dependencies. Used by the top level and the checker.
package lss_pkg;

    localparam int STACK_DEPTH_DEF = 16;
    localparam int DATA_W          = 32;
    localparam int ACT_W           = 2;
    localparam int STAT_W          = 2;
    localparam int FILL_W          = 5;

    typedef enum logic [ACT_W-1:0] {
        ACT_PUSH   = 2'd0,
        ACT_POP    = 2'd1,
        ACT_SEARCH = 2'd2
    } t_action;

    typedef enum logic [STAT_W-1:0] {
        ST_OK        = 2'd0,
        ST_UNDERFLOW = 2'd1,
        ST_OVERFLOW  = 2'd2
    } t_status;

endpackage

>>> hdl/lss_ram.sv
// lss_ram: generic single-write, single-read RAM with a registered read port.
// No dependencies.
module lss_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> hdl/lifo_stack_with_search_top.sv
// LIFO stack with search: bounded stack of signed words held in one lss_ram.
// Push, refusals, unused codes, search of an empty stack and pop of the last entry: result
// registered at transfer; other pops wait in S_POP for the RAM read of the new top.
// Search reads one entry per cycle from the top down, early out on match.
// Throughput: one item at a time; next transfer once idle and the result register is free.
// Reset (synchronous, active low) empties the stack at once; RAM contents are not cleared.
module lifo_stack_with_search_top #(
    parameter int STACK_DEPTH = lss_pkg::STACK_DEPTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // input channel
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic [lss_pkg::ACT_W-1:0]         i_action,
    input  logic signed [lss_pkg::DATA_W-1:0] i_operand_value,
    // result channel
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [lss_pkg::STAT_W-1:0]        o_status,
    output logic signed [lss_pkg::DATA_W-1:0] o_popped_value,
    output logic                              o_found,
    output logic signed [lss_pkg::DATA_W-1:0] o_top_value,
    output logic                              o_stack_empty,
    output logic [lss_pkg::FILL_W-1:0]        o_fill_count
);

    // count needs to hold DEPTH itself; RAM address only DEPTH-1
    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam int AW = $clog2(STACK_DEPTH);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_POP  = 3'b010,   // waiting on RAM read of the new top
        S_SRCH = 3'b100    // walking entries, one compare per cycle
    } t_state;

    t_state                      r_state, n_state;
    logic [CW-1:0]               r_count, n_count;
    logic [lss_pkg::DATA_W-1:0]  r_top,   n_top;     // cached top entry
    logic [lss_pkg::DATA_W-1:0]  r_key,   n_key;     // search value
    logic [AW-1:0]               r_idx,   n_idx;     // address of entry now on RAM output

    // result register
    logic                        r_out_valid, n_out_valid;
    logic [lss_pkg::STAT_W-1:0]  r_status,    n_status;
    logic [lss_pkg::DATA_W-1:0]  r_popped,    n_popped;
    logic                        r_found,     n_found;
    logic [lss_pkg::DATA_W-1:0]  r_otop,      n_otop;
    logic                        r_oempty,    n_oempty;
    logic [lss_pkg::FILL_W-1:0]  r_ofill,     n_ofill;

    // RAM port
    logic                        w_we;
    logic [AW-1:0]               w_waddr;
    logic [lss_pkg::DATA_W-1:0]  w_wdata;
    logic [AW-1:0]               w_raddr;
    logic [lss_pkg::DATA_W-1:0]  w_rdata;

    logic                        w_in_acc;
    logic                        w_emit;
    logic [lss_pkg::STAT_W-1:0]  w_status;
    logic [lss_pkg::DATA_W-1:0]  w_popped;
    logic                        w_found;

    lss_ram #(
        .WIDTH (lss_pkg::DATA_W),
        .DEPTH (STACK_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // Result register is free at a transfer edge, so busy states never stall on output.
    assign o_in_ready = (r_state == S_IDLE) && (!r_out_valid || i_out_ready);
    assign w_in_acc   = o_in_ready && i_in_valid;

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_top       = r_top;
        n_key       = r_key;
        n_idx       = r_idx;
        n_out_valid = r_out_valid && !i_out_ready;
        n_status    = r_status;
        n_popped    = r_popped;
        n_found     = r_found;
        n_otop      = r_otop;
        n_oempty    = r_oempty;
        n_ofill     = r_ofill;

        w_we     = 1'b0;
        w_waddr  = r_count[AW-1:0];
        w_wdata  = i_operand_value;
        w_raddr  = r_idx;
        w_emit   = 1'b0;
        w_status = lss_pkg::ST_OK;
        w_popped = '0;
        w_found  = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                // pop wants the entry below the top; search starts at the top
                if (i_action == lss_pkg::ACT_POP) begin
                    w_raddr = AW'(r_count - CW'(2));
                end else begin
                    w_raddr = AW'(r_count - CW'(1));
                end
                if (w_in_acc) begin
                    if (i_action == lss_pkg::ACT_PUSH) begin
                        w_emit = 1'b1;
                        if (r_count == CW'(STACK_DEPTH)) begin
                            w_status = lss_pkg::ST_OVERFLOW;
                        end else begin
                            w_we    = 1'b1;
                            n_count = r_count + CW'(1);
                            n_top   = i_operand_value;
                        end
                    end else if (i_action == lss_pkg::ACT_POP) begin
                        if (r_count == '0) begin
                            w_emit   = 1'b1;
                            w_status = lss_pkg::ST_UNDERFLOW;
                        end else begin
                            n_count  = r_count - CW'(1);
                            w_popped = r_top;
                            if (r_count == CW'(1)) begin
                                w_emit = 1'b1;
                            end else begin
                                n_popped = r_top;   // held until the new top arrives
                                n_state  = S_POP;
                            end
                        end
                    end else if (i_action == lss_pkg::ACT_SEARCH) begin
                        n_key = i_operand_value;
                        if (r_count == '0) begin
                            w_emit = 1'b1;
                        end else begin
                            n_idx   = AW'(r_count - CW'(1));
                            n_state = S_SRCH;
                        end
                    end else begin
                        // unused code: report unchanged stack
                        w_emit = 1'b1;
                    end
                end
            end
            S_POP: begin
                n_top    = w_rdata;
                w_popped = r_popped;
                w_emit   = 1'b1;
                n_state  = S_IDLE;
            end
            S_SRCH: begin
                if (w_rdata == r_key) begin
                    w_found = 1'b1;
                    w_emit  = 1'b1;
                    n_state = S_IDLE;
                end else if (r_idx == '0) begin
                    w_emit  = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    n_idx   = r_idx - AW'(1);
                    w_raddr = r_idx - AW'(1);
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (w_emit) begin
            n_out_valid = 1'b1;
            n_status    = w_status;
            n_popped    = w_popped;
            n_found     = w_found;
            n_otop      = (n_count == '0) ? '0 : n_top;
            n_oempty    = (n_count == '0);
            n_ofill     = lss_pkg::FILL_W'(n_count);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
        r_top    <= n_top;
        r_key    <= n_key;
        r_idx    <= n_idx;
        r_status <= n_status;
        r_popped <= n_popped;
        r_found  <= n_found;
        r_otop   <= n_otop;
        r_oempty <= n_oempty;
        r_ofill  <= n_ofill;
    end

    assign o_out_valid    = r_out_valid;
    assign o_status       = r_status;
    assign o_popped_value = r_popped;
    assign o_found        = r_found;
    assign o_top_value    = r_otop;
    assign o_stack_empty  = r_oempty;
    assign o_fill_count   = r_ofill;

endmodule

>>> hdl/lss_checker.sv
// lss_checker: port-level assertions for the LIFO stack with search, bound to the top level.
// Depends on lss_pkg and lifo_stack_with_search_top.
module lss_checker #(
    parameter int STACK_DEPTH = lss_pkg::STACK_DEPTH_DEF
) (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_in_valid,
    input logic                              o_in_ready,
    input logic [lss_pkg::ACT_W-1:0]         i_action,
    input logic signed [lss_pkg::DATA_W-1:0] i_operand_value,
    input logic                              o_out_valid,
    input logic                              i_out_ready,
    input logic [lss_pkg::STAT_W-1:0]        o_status,
    input logic signed [lss_pkg::DATA_W-1:0] o_popped_value,
    input logic                              o_found,
    input logic signed [lss_pkg::DATA_W-1:0] o_top_value,
    input logic                              o_stack_empty,
    input logic [lss_pkg::FILL_W-1:0]        o_fill_count
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result dropped before transfer");

    a_empty_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_stack_empty == (o_fill_count == '0)))
        else $error("empty flag disagrees with fill count");

    a_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status == lss_pkg::ST_UNDERFLOW)
            |-> o_stack_empty && (o_popped_value == '0))
        else $error("underflow on a non-empty stack");

    a_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status == lss_pkg::ST_OVERFLOW)
            |-> (o_fill_count == lss_pkg::FILL_W'(STACK_DEPTH)) && !o_found)
        else $error("overflow reported below full");

    a_empty_top: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_stack_empty |-> (o_top_value == '0) && !o_found)
        else $error("empty stack shows a top or a match");

endmodule

bind lifo_stack_with_search_top lss_checker #(.STACK_DEPTH(STACK_DEPTH)) u_lss_checker (.*);
